// ===== rtl/cpr_dpe_pkg.sv =====
// Shared types, constants and table-building functions for the CPR diastolic
// pressure estimator. No dependencies; imported by every other file in rtl/.
package cpr_dpe_pkg;

   // Input metrics of one compression.
   typedef struct packed {
      logic [10:0] compression_depth;
      logic [11:0] compression_rate;
      logic [11:0] hand_offset;
      logic [9:0]  residual_lean;
      logic        is_paused;
   } req_type;

   // One estimate.
   typedef struct packed {
      logic signed [15:0] pressure_estimate;
      logic               saturated;
   } rsp_type;

   // Classified item handed from front to back: depth plus Q1.15 factors.
   typedef struct packed {
      logic [10:0] depth;
      logic [15:0] rate_fac;
      logic [15:0] place_fac;
      logic [15:0] lean_fac;
      logic        paused;
   } item_type;

   localparam int TABLE_ADDR_BITS_DEF = 8;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [15:0] UNITY_Q15 = 16'd32768;
   localparam logic signed [16:0] PAUSE_Q15 = 17'sd21955;

   // Cubic coefficients, Q44 of mmHg
   localparam logic signed [33:0] CUB3_C = -34'sd1937030;
   localparam logic signed [33:0] CUB2_C = 34'sd2112642873;
   localparam logic signed [45:0] CUB1_C = 46'sd271534292084;
   localparam logic signed [55:0] CUB0_C = 56'sd87960930222080;

   // Falling rate line: 45056 - round(R*128/25); /25 via reciprocal
   localparam logic [15:0] RATE_LINE_BASE = 16'd45056;
   localparam logic [21:0] DIV25_MUL = 22'd2684355;   // ceil(2^26/25)
   localparam int          DIV25_SHIFT = 26;

   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint LN2_Q30 = 64'sd744261118;

   // Truncating signed quotient by shift and subtract; table contents only
   function automatic longint sdiv(input longint num, input longint den);
      logic [63:0] n_mag;
      logic [63:0] d_mag;
      logic [63:0] quo;
      logic [64:0] rem;
      n_mag = (num < 64'sd0) ? 64'(-num) : 64'(num);
      d_mag = (den < 64'sd0) ? 64'(-den) : 64'(den);
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n_mag[b]};
         if (rem >= {1'b0, d_mag}) begin
            rem = rem - {1'b0, d_mag};
            quo[b] = 1'b1;
         end
      end
      if ((num < 64'sd0) != (den < 64'sd0)) begin
         return -longint'(quo);
      end
      return longint'(quo);
   endfunction

   // e^(+-f), f in [0,1], Q30
   function automatic longint exp_series(input longint f, input bit neg);
      longint sum;
      longint term;
      sum = ONE_Q30;
      term = ONE_Q30;
      for (int n = 1; n <= 24; n++) begin
         term = sdiv((term * f) >>> 30, longint'(n));
         if (neg && n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // e^(-a), a >= 0, Q30
   function automatic longint exp_neg(input longint a);
      longint m;
      longint r;
      longint stp;
      m = a >>> 30;
      r = exp_series(a & (ONE_Q30 - 64'sd1), 1'b1);
      if (m > 64'sd40) begin
         return 64'sd0;
      end
      stp = exp_series(ONE_Q30, 1'b1);
      while (m > 64'sd0) begin
         r = (r * stp + (ONE_Q30 >>> 1)) >>> 30;
         m = m - 64'sd1;
      end
      return r;
   endfunction

   function automatic longint exp_q30(input longint y);
      longint u;
      if (y <= 64'sd0) begin
         return exp_neg(-y);
      end
      u = exp_neg(y);
      if (u <= 64'sd0) begin
         return 64'sd1 <<< 62;
      end
      return sdiv((64'sd1 <<< 60) + (u >>> 1), u);
   endfunction

   // ln(y), y > 0, Q30
   function automatic longint ln_q30(input longint y);
      longint n;
      longint yy;
      longint t;
      longint t2;
      longint term;
      longint sum;
      n = 64'sd0;
      yy = y;
      if (yy <= 64'sd0) begin
         return 64'sd0;
      end
      while (yy >= 64'sd2 * ONE_Q30) begin
         yy = yy >>> 1;
         n = n + 64'sd1;
      end
      while (yy < ONE_Q30) begin
         yy = yy <<< 1;
         n = n - 64'sd1;
      end
      t = sdiv((yy - ONE_Q30) <<< 30, yy + ONE_Q30);
      t2 = (t * t) >>> 30;
      sum = t;
      term = t;
      for (int k = 3; k <= 41; k += 2) begin
         term = (term * t2) >>> 30;
         sum = sum + sdiv(term, longint'(k));
      end
      return 64'sd2 * sum + n * LN2_Q30;
   endfunction

   // Logistic knot k, Q1.15
   function automatic logic [31:0] logi_entry(input int k, input int ab);
      longint x;
      longint u;
      longint den;
      longint v;
      x = (longint'(k) <<< (34 - ab)) - 64'sd10 * ONE_Q30;
      u = exp_neg((x < 64'sd0) ? -x : x);
      den = ONE_Q30 + u;
      if (x >= 64'sd0) begin
         v = sdiv((ONE_Q30 <<< 15) + (den >>> 1), den);
      end else begin
         v = sdiv((u <<< 15) + (den >>> 1), den);
      end
      return v[31:0];
   endfunction

   // Lean factor knot k, Q1.15, clamped at 0
   function automatic logic [31:0] leanf_entry(input int k, input int ab);
      longint w;
      longint pw;
      longint pen;
      longint v;
      w = ln_q30((longint'(k) <<< (36 - ab)) + ONE_Q30);
      if (k == 0 || w <= 64'sd0) begin
         v = 64'sd32768;
      end else begin
         pw = exp_q30(sdiv(ln_q30(w) * 64'sd162, 64'sd100));
         pen = sdiv(pw * 64'sd501, 64'sd10000);
         v = 64'sd32768 - ((pen + 64'sd16384) >>> 15);
         if (v < 64'sd0) begin
            v = 64'sd0;
         end
      end
      return v[31:0];
   endfunction

   // 1/m^2 knot k, Q30
   function automatic logic [31:0] rsq_entry(input int k, input int ab);
      longint segs;
      longint nn;
      longint dd;
      longint v;
      segs = 64'sd1 <<< ab;
      nn = segs * segs;
      dd = (segs + longint'(k)) * (segs + longint'(k));
      v = sdiv((nn <<< 30) + (dd >>> 1), dd);
      return v[31:0];
   endfunction

endpackage

// ===== rtl/cpr_dpe_front.sv =====
// Front end: accepts metric transfers, classifies them and works out the rate,
// placement and lean factors from interpolated tables. Uses cpr_dpe_pkg.
module cpr_dpe_front
   import cpr_dpe_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     q_full,
   output logic     q_push,
   output item_type q_item
);

   localparam int AB    = TABLE_ADDR_BITS;
   localparam int SEGS  = 1 << AB;
   localparam int KNOTS = SEGS + 1;
   localparam int IW    = AB + 1;
   localparam int WBH   = 22 - AB;
   localparam logic [WBH:0]  PL_ONE  = (WBH + 1)'(1) << WBH;
   localparam logic [48:0]   PL_HALF = 49'(1) << (WBH - 1);

   // constant tables
   logic [15:0] logi_rom [KNOTS];
   logic [15:0] lean_rom [KNOTS];
   logic [30:0] rsq_rom  [KNOTS];

   for (genvar k = 0; k < KNOTS; k++) begin : g_rom
      localparam logic [31:0] LOGI_V = logi_entry(k, AB);
      localparam logic [31:0] LEAN_V = leanf_entry(k, AB);
      localparam logic [31:0] RSQ_V  = rsq_entry(k, AB);
      assign logi_rom[k] = LOGI_V[15:0];
      assign lean_rom[k] = LEAN_V[15:0];
      assign rsq_rom[k]  = RSQ_V[30:0];
   end

   logic advance;

   // ---- stage 1: input register
   logic    f1_vld_ff, f1_vld_in;
   req_type f1_ff;

   // ---- stage 2: classification
   logic              f2_vld_ff;
   logic [10:0]       f2_d_ff;
   logic              f2_pz_ff, f2_rlo_ff, f2_rhi_ff, f2_hsm_ff, f2_lz_ff;
   logic [AB-1:0]     f2_ridx_ff, f2_pidx_ff, f2_lidx_ff;
   logic [9:0]        f2_rfrac_ff, f2_lfrac_ff;
   logic [WBH-1:0]    f2_pfrac_ff;
   logic [14:0]       f2_q25_ff;
   logic [3:0]        f2_e_ff;

   // ---- stage 3: table reads
   logic              f3_vld_ff;
   logic [10:0]       f3_d_ff;
   logic              f3_pz_ff, f3_rlo_ff, f3_rhi_ff, f3_hsm_ff, f3_lz_ff;
   logic [15:0]       f3_rlo_v_ff, f3_rhi_v_ff, f3_llo_v_ff, f3_lhi_v_ff, f3_rlin_ff;
   logic [30:0]       f3_plo_v_ff, f3_phi_v_ff;
   logic [9:0]        f3_rfrac_ff, f3_lfrac_ff;
   logic [WBH-1:0]    f3_pfrac_ff;
   logic [3:0]        f3_e_ff;

   // ---- stage 4: interpolation sums
   logic              f4_vld_ff;
   logic [10:0]       f4_d_ff;
   logic              f4_pz_ff, f4_rlo_ff, f4_rhi_ff, f4_hsm_ff, f4_lz_ff;
   logic [27:0]       f4_rsum_ff, f4_lsum_ff;
   logic [48:0]       f4_psum_ff;
   logic [15:0]       f4_rlin_ff;
   logic [3:0]        f4_e_ff;

   assign advance   = !(f4_vld_ff && q_full);
   assign req_stall = !advance;
   assign f1_vld_in = req_valid;
   assign q_push    = f4_vld_ff && !q_full;

   // classification
   logic [11:0]    ca_r, ca_h;
   logic [9:0]     ca_l;
   logic [AB+9:0]  ca_rsh, ca_lsh;
   logic [18:0]    ca_num;
   logic [40:0]    ca_prod;
   logic [3:0]     ca_e;
   logic [11:0]    ca_hf;
   logic [21:0]    ca_mf;

   always_comb begin
      ca_r   = f1_ff.compression_rate;
      ca_h   = f1_ff.hand_offset;
      ca_l   = f1_ff.residual_lean;
      ca_rsh = {ca_r[9:0], {AB{1'b0}}};
      ca_lsh = {ca_l, {AB{1'b0}}};
      ca_num = {ca_r, 7'b0} + 19'd12;
      ca_prod = 41'(ca_num) * 41'(DIV25_MUL);
      ca_e = 4'd0;
      for (int i = 0; i < 12; i++) begin
         if (ca_h[i]) begin
            ca_e = 4'(i);
         end
      end
      ca_hf = ca_h & ~(12'd1 << ca_e);
      ca_mf = {10'b0, ca_hf} << (5'd22 - 5'(ca_e));
   end

   // table reads
   logic [IW-1:0] rd_r, rd_p, rd_l;
   assign rd_r = {1'b0, f2_ridx_ff};
   assign rd_p = {1'b0, f2_pidx_ff};
   assign rd_l = {1'b0, f2_lidx_ff};

   // interpolation
   logic [27:0] ic_rsum, ic_lsum;
   logic [48:0] ic_psum;
   always_comb begin
      ic_rsum = 28'(f3_rlo_v_ff) * 28'(11'd1024 - {1'b0, f3_rfrac_ff})
              + 28'(f3_rhi_v_ff) * 28'(f3_rfrac_ff) + 28'd512;
      ic_lsum = 28'(f3_llo_v_ff) * 28'(11'd1024 - {1'b0, f3_lfrac_ff})
              + 28'(f3_lhi_v_ff) * 28'(f3_lfrac_ff) + 28'd512;
      ic_psum = 49'(f3_plo_v_ff) * 49'(PL_ONE - {1'b0, f3_pfrac_ff})
              + 49'(f3_phi_v_ff) * 49'(f3_pfrac_ff) + PL_HALF;
   end

   // final factor selection
   logic [30:0] fd_rv;
   logic [4:0]  fd_sh;
   logic [31:0] fd_rnd, fd_pf;
   always_comb begin
      fd_rv  = f4_psum_ff[WBH+30:WBH];
      fd_sh  = {f4_e_ff, 1'b0} + 5'd7;
      fd_rnd = 32'(fd_rv) + (32'd1 << (fd_sh - 5'd1));
      fd_pf  = fd_rnd >> fd_sh;
      q_item.depth  = f4_d_ff;
      q_item.paused = f4_pz_ff;
      if (f4_rlo_ff) begin
         q_item.rate_fac = f4_rsum_ff[25:10];
      end else if (f4_rhi_ff) begin
         q_item.rate_fac = f4_rlin_ff;
      end else begin
         q_item.rate_fac = UNITY_Q15;
      end
      q_item.place_fac = f4_hsm_ff ? UNITY_Q15 : fd_pf[15:0];
      q_item.lean_fac  = f4_lz_ff ? UNITY_Q15 : f4_lsum_ff[25:10];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
         f4_vld_ff <= 1'b0;
      end else if (advance) begin
         f1_vld_ff <= f1_vld_in;
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
         f4_vld_ff <= f3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ff <= req_data;

         f2_d_ff     <= f1_ff.compression_depth;
         f2_pz_ff    <= f1_ff.is_paused;
         f2_rlo_ff   <= ca_r < 12'd960;
         f2_rhi_ff   <= ca_r > 12'd2400;
         f2_ridx_ff  <= ca_rsh[AB+9:10];
         f2_rfrac_ff <= ca_rsh[9:0];
         f2_q25_ff   <= ca_prod[40:DIV25_SHIFT];
         f2_hsm_ff   <= ca_h <= 12'd16;
         f2_e_ff     <= ca_e;
         f2_pidx_ff  <= ca_mf[21:WBH];
         f2_pfrac_ff <= ca_mf[WBH-1:0];
         f2_lz_ff    <= ca_l == 10'd0;
         f2_lidx_ff  <= ca_lsh[AB+9:10];
         f2_lfrac_ff <= ca_lsh[9:0];

         f3_d_ff     <= f2_d_ff;
         f3_pz_ff    <= f2_pz_ff;
         f3_rlo_ff   <= f2_rlo_ff;
         f3_rhi_ff   <= f2_rhi_ff;
         f3_hsm_ff   <= f2_hsm_ff;
         f3_lz_ff    <= f2_lz_ff;
         f3_rlo_v_ff <= logi_rom[rd_r];
         f3_rhi_v_ff <= logi_rom[rd_r + IW'(1)];
         f3_llo_v_ff <= lean_rom[rd_l];
         f3_lhi_v_ff <= lean_rom[rd_l + IW'(1)];
         f3_plo_v_ff <= rsq_rom[rd_p];
         f3_phi_v_ff <= rsq_rom[rd_p + IW'(1)];
         f3_rlin_ff  <= RATE_LINE_BASE - {1'b0, f2_q25_ff};
         f3_rfrac_ff <= f2_rfrac_ff;
         f3_lfrac_ff <= f2_lfrac_ff;
         f3_pfrac_ff <= f2_pfrac_ff;
         f3_e_ff     <= f2_e_ff;

         f4_d_ff    <= f3_d_ff;
         f4_pz_ff   <= f3_pz_ff;
         f4_rlo_ff  <= f3_rlo_ff;
         f4_rhi_ff  <= f3_rhi_ff;
         f4_hsm_ff  <= f3_hsm_ff;
         f4_lz_ff   <= f3_lz_ff;
         f4_rsum_ff <= ic_rsum;
         f4_lsum_ff <= ic_lsum;
         f4_psum_ff <= ic_psum;
         f4_rlin_ff <= f3_rlin_ff;
         f4_e_ff    <= f3_e_ff;
      end
   end

endmodule

// ===== rtl/cpr_dpe_queue.sv =====
// Small FIFO of classified items between front and back end.
// Uses item_type and QUEUE_DEPTH from cpr_dpe_pkg.
module cpr_dpe_queue
   import cpr_dpe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full  = cnt_ff == CW'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/cpr_dpe_back.sv =====
// Back end: cubic base pressure, factor multiplies with rounding, final
// saturation and the result register. Uses cpr_dpe_pkg.
module cpr_dpe_back
   import cpr_dpe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   output logic     q_pop,
   input  item_type q_head,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int NST = 12;

   logic             advance;
   logic [NST-1:0]   vld_ff, vld_in;
   item_type         itm_ff [10];
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   logic signed [33:0] p1_ff, p1_in;
   logic signed [45:0] p2_ff, p2_in;
   logic signed [55:0] p3_ff, p3_in;
   logic signed [31:0] base_ff, base_in, a1_ff, a1_in, a2_ff, a2_in;
   logic signed [31:0] a3_ff, a3_in, a4_ff, a4_in;
   logic signed [48:0] m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in, m4_ff, m4_in;

   logic signed [11:0] d_s0, d_s1, d_s2;
   logic signed [16:0] fr_s, fp_s, fl_s;
   logic signed [55:0] b_sum;
   logic signed [48:0] r1_sum, r2_sum, r3_sum, r4_sum;
   logic signed [32:0] q_sum, q_sh;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = !q_empty && advance;
   assign vld_in    = {vld_ff[NST-2:0], q_pop};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      d_s0 = signed'({1'b0, q_head.depth});
      d_s1 = signed'({1'b0, itm_ff[0].depth});
      d_s2 = signed'({1'b0, itm_ff[1].depth});
      fr_s = signed'({1'b0, itm_ff[3].rate_fac});
      fp_s = signed'({1'b0, itm_ff[5].place_fac});
      fl_s = signed'({1'b0, itm_ff[7].lean_fac});

      // cubic by Horner, exact
      p1_in = CUB3_C * 34'(d_s0) + CUB2_C;
      p2_in = 46'(p1_ff) * 46'(d_s1) + CUB1_C;
      p3_in = 56'(p2_ff) * 56'(d_s2) + CUB0_C;

      // Q44 -> Q20, round half up
      b_sum   = p3_ff + (56'sd1 <<< 23);
      base_in = 32'(b_sum >>> 24);

      m1_in  = 49'(base_ff) * 49'(fr_s);
      r1_sum = m1_ff + 49'sd16384;
      a1_in  = 32'(r1_sum >>> 15);

      m2_in  = 49'(a1_ff) * 49'(fp_s);
      r2_sum = m2_ff + 49'sd16384;
      a2_in  = 32'(r2_sum >>> 15);

      m3_in  = 49'(a2_ff) * 49'(fl_s);
      r3_sum = m3_ff + 49'sd16384;
      a3_in  = 32'(r3_sum >>> 15);

      // unpaused: scale by one, rounds back to the same value
      m4_in  = itm_ff[9].paused ? 49'(a3_ff) * 49'(PAUSE_Q15) : 49'(a3_ff) <<< 15;
      r4_sum = m4_ff + 49'sd16384;
      a4_in  = 32'(r4_sum >>> 15);

      // Q20 -> Q6 and clamp
      q_sum = 33'(a4_ff) + 33'sd8192;
      q_sh  = q_sum >>> 14;
      if (q_sh > 33'sd32767) begin
         rsp_in.pressure_estimate = 16'sh7FFF;
         rsp_in.saturated         = 1'b1;
      end else if (q_sh < -33'sd32768) begin
         rsp_in.pressure_estimate = 16'sh8000;
         rsp_in.saturated         = 1'b1;
      end else begin
         rsp_in.pressure_estimate = q_sh[15:0];
         rsp_in.saturated         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         itm_ff[0] <= q_head;
         for (int k = 1; k < 10; k++) begin
            itm_ff[k] <= itm_ff[k-1];
         end
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         p3_ff   <= p3_in;
         base_ff <= base_in;
         m1_ff   <= m1_in;
         a1_ff   <= a1_in;
         m2_ff   <= m2_in;
         a2_ff   <= a2_in;
         m3_ff   <= m3_in;
         a3_ff   <= a3_in;
         m4_ff   <= m4_in;
         a4_ff   <= a4_in;
         rsp_ff  <= rsp_in;
      end
   end

endmodule

// ===== rtl/cpr_diastolic_pressure_estimator_top.sv =====
// CPR diastolic pressure estimator, top level: front end, item queue, back end.
// Depends on cpr_dpe_pkg, cpr_dpe_front, cpr_dpe_queue and cpr_dpe_back.
//
// Usage:
//  - req channel: one transfer per compression carries depth, rate, hand
//    offset, residual lean and the pause flag (req_valid / req_stall).
//  - rsp channel: one transfer per request carries the estimate in 1/64 mmHg
//    and a saturation flag (rsp_valid / rsp_stall), in request order.
//  - Pipeline: 4 front stages, 1 queue slot, 12 back stages and the result
//    register lie between a req transfer and rsp_valid.
//  - Throughput: one item per cycle while no stall holds the pipes; each back
//    stage is a plain register stage doing one multiply(-add) or one round.
//  - The front end holds the curve tables as constant logic, two reads per
//    table per item for linear interpolation.
//  - Stall: rsp_stall freezes the back pipeline and its result register; the
//    four-entry queue keeps the front end taking transfers until it fills,
//    and only then is req_stall raised.
//  - Reset (synchronous, active high) empties all stages and the queue; no
//    clearing pass is needed, the block takes transfers the cycle after.
module cpr_diastolic_pressure_estimator_top
   import cpr_dpe_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     q_full, q_empty, q_push, q_pop;
   item_type q_in_item, q_head;

   // classify and look up factors
   cpr_dpe_front #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in_item)
   );

   // decouples the two halves
   cpr_dpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // base pressure and factor chain
   cpr_dpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_head    (q_head),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
